// File: sv/encoder_gear_shift_sequencer_assert.svh
// Assertion helpers shared by the sequencer RTL.
`ifndef ENCODER_GEAR_SHIFT_SEQUENCER_ASSERT_SVH
`define ENCODER_GEAR_SHIFT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define EGSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Next-cycle implication, disabled while reset is low.
`define EGSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

// File: sv/egss_pkg.sv
package egss_pkg;

    localparam int TOP_GEAR_DEF   = 6;
    localparam int COUNT_BITS_DEF = 16;

    localparam int GEAR_W    = 3;
    localparam int TIMEOUT_W = 16;
    localparam int TRAVEL_W  = 15;
    localparam int PULSE_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd500;
    localparam logic [TRAVEL_W-1:0]  TRAVEL_RST  = 15'd512;
    localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX = 16'hFFFF;

    localparam logic [PULSE_W-1:0] PULSE_STOP = 11'd1500;
    localparam logic [PULSE_W-1:0] PULSE_UP   = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_DOWN = 11'd2000;

    localparam logic [GEAR_W-1:0] GEAR_FIRST = 3'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL  = 2'd1;

    typedef enum logic [2:0] {
        STAT_NONE       = 3'd0,
        STAT_UP_DONE    = 3'd1,
        STAT_DOWN_DONE  = 3'd2,
        STAT_UP_ABORT   = 3'd3,
        STAT_DOWN_ABORT = 3'd4,
        STAT_CONFLICT   = 3'd5
    } t_status;

    typedef struct packed {
        logic enc_a;
        logic enc_b;
        logic up_press;
        logic down_press;
        logic ms_tick;
    } t_in_word;

    typedef struct packed {
        logic [GEAR_W-1:0]  gear_now;
        logic [7:0]         ecu_duty;
        logic [PULSE_W-1:0] motor_pulse_us;
        logic               shift_led;
        logic [2:0]         shift_status;
        logic signed [15:0] travel_count;
    } t_out_word;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [TRAVEL_W-1:0]  travel;
    } t_cfg;

    // Inverted ECU duty: 255 - 51 * (gear - 1), clamped to 0..255.
    function automatic logic [7:0] duty_lut(input logic [GEAR_W-1:0] gear);
        logic [7:0] duty;
        case (gear)
            3'd0:    duty = 8'd255;
            3'd1:    duty = 8'd255;
            3'd2:    duty = 8'd204;
            3'd3:    duty = 8'd153;
            3'd4:    duty = 8'd102;
            3'd5:    duty = 8'd51;
            default: duty = 8'd0;
        endcase
        return duty;
    endfunction

endpackage

// File: sv/encoder_gear_shift_sequencer.sv
// Encoder gear shift sequencer.
// Input channel (i_in_valid / o_in_ready / i_in_word): one word per ready clock with the
// sampled encoder levels, up/down press events and a millisecond tick.
// Output channel (o_out_valid / i_out_ready / o_out_word): one word per input word
// with gear, inverted ECU duty, motor pulse width, LED, status and travel count.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data): index 0 is
// the shift timeout in ms, index 1 the travel count; other indexes are dropped.
// The port is always ready; write it only while no word is in flight.
// Path: an accepted word is held in two registers, the input word register and
// then the result register. Throughput: one word per clock while the receiver
// takes results, set by the single-pass decode and shift logic between them.
// Stall: when the receiver holds i_out_ready low, the result register holds and
// the input register still takes one more word; then o_in_ready drops.
// Reset (synchronous, active low): gear 1, count and timer zero, no pending
// shift, timeout 500 ms, travel 512 counts, both channels empty.
module encoder_gear_shift_sequencer import egss_pkg::*; #(
    parameter int TOP_GEAR   = TOP_GEAR_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

`include "encoder_gear_shift_sequencer_assert.svh"

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_cfg      r_cfg;
    t_out_word step_word;
    logic      adv_out;
    logic      step;

    // Result slot frees when empty or being taken this cycle.
    assign adv_out    = ~r_out_valid | i_out_ready;
    assign step       = r_in_valid & adv_out;
    assign o_in_ready = ~r_in_valid | adv_out;
    assign o_cfg_ready = 1'b1;

    // Latch the config registers; drop writes beyond the register list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms <= TIMEOUT_RST;
            r_cfg.travel     <= TRAVEL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_cfg.timeout_ms <= i_cfg_data;
                CFG_TRAVEL:  r_cfg.travel     <= i_cfg_data[TRAVEL_W-1:0];
                default:     ;
            endcase
        end
    end

    // Input word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    // Decode, latch requests and run the shift sequence in one pass.
    egss_shift #(
        .TOP_GEAR   (TOP_GEAR),
        .COUNT_BITS (COUNT_BITS)
    ) u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in_word),
        .i_cfg   (r_cfg),
        .o_word  (step_word)
    );

    // Result register: advance when the slot frees, hold under stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= step_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `EGSS_ASSERT_NEXT(a_step_fills_out, i_clk, i_rst_n, step, r_out_valid)
    `EGSS_ASSERT_NOW(a_gear_range, i_clk, i_rst_n, r_out_valid, (r_out_word.gear_now >= GEAR_FIRST) && (r_out_word.gear_now <= GEAR_W'(TOP_GEAR)))
    `EGSS_ASSERT_NOW(a_led_drives, i_clk, i_rst_n, r_out_valid && r_out_word.shift_led, r_out_word.motor_pulse_us != PULSE_STOP)
    `EGSS_ASSERT_NOW(a_end_stops, i_clk, i_rst_n, r_out_valid && (r_out_word.shift_status != STAT_NONE), (!r_out_word.shift_led) && (r_out_word.motor_pulse_us == PULSE_STOP))

endmodule

// File: sv/egss_quad.sv
module egss_quad import egss_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                         i_a,
    input  logic                         i_b,
    input  logic                         i_last_a,
    input  logic                         i_last_b,
    input  logic signed [COUNT_BITS-1:0] i_count,
    output logic signed [COUNT_BITS-1:0] o_count
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic da;
    logic db;
    logic step_up;
    logic step_dn;

    assign da = i_a ^ i_last_a;
    assign db = i_b ^ i_last_b;

    // Single-line change only; both lines flipping is a lost step.
    assign step_up = (da & ~db & (i_a ^ i_b)) | (db & ~da & ~(i_a ^ i_b));
    assign step_dn = (da & ~db & ~(i_a ^ i_b)) | (db & ~da & (i_a ^ i_b));

    always_comb begin
        o_count = i_count;
        if (step_up && (i_count != CNT_MAX)) begin
            o_count = i_count + COUNT_BITS'(1);
        end else if (step_dn && (i_count != CNT_MIN)) begin
            o_count = i_count - COUNT_BITS'(1);
        end
    end

endmodule

// File: sv/egss_shift.sv
module egss_shift import egss_pkg::*; #(
    parameter int TOP_GEAR   = TOP_GEAR_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_word
);

    localparam int CMP_W = ((COUNT_BITS > TRAVEL_W) ? COUNT_BITS : TRAVEL_W) + 2;

    logic signed [COUNT_BITS-1:0] r_count;
    logic signed [COUNT_BITS-1:0] n_count;
    logic signed [COUNT_BITS-1:0] dec_count;
    logic                         r_last_a;
    logic                         r_last_b;
    logic                         r_up_pend;
    logic                         n_up_pend;
    logic                         r_dn_pend;
    logic                         n_dn_pend;
    logic                         r_up_idle;
    logic                         n_up_idle;
    logic                         r_dn_idle;
    logic                         n_dn_idle;
    logic [TIMEOUT_W-1:0]         r_elapsed;
    logic [TIMEOUT_W-1:0]         n_elapsed;
    logic [TIMEOUT_W-1:0]         el_tick;
    logic [GEAR_W-1:0]            r_gear;
    logic [GEAR_W-1:0]            n_gear;

    logic                 up_req;
    logic                 dn_req;
    logic                 conflict;
    logic                 up_go;
    logic                 dn_go;
    logic                 up_ref;
    logic                 dn_ref;
    logic                 up_start;
    logic                 dn_start;
    logic                 in_time;
    logic                 up_done;
    logic                 dn_done;
    logic signed [CMP_W-1:0] cnt_x;
    logic signed [CMP_W-1:0] thr_x;
    logic [PULSE_W-1:0]   pulse;
    logic                 led;
    t_status              status;

    egss_quad #(
        .COUNT_BITS(COUNT_BITS)
    ) u_quad (
        .i_a      (i_word.enc_a),
        .i_b      (i_word.enc_b),
        .i_last_a (r_last_a),
        .i_last_b (r_last_b),
        .i_count  (r_count),
        .o_count  (dec_count)
    );

    assign up_req   = r_up_pend | i_word.up_press;
    assign dn_req   = r_dn_pend | i_word.down_press;
    assign conflict = up_req & dn_req;
    assign up_go    = up_req & ~conflict;
    assign dn_go    = dn_req & ~conflict;
    assign up_ref   = r_gear >= GEAR_W'(TOP_GEAR);
    assign dn_ref   = r_gear <= GEAR_FIRST;
    assign up_start = up_go & ~up_ref & r_up_idle;
    assign dn_start = dn_go & ~dn_ref & r_dn_idle;

    assign el_tick  = (i_word.ms_tick && (r_elapsed != ELAPSED_MAX))
                    ? r_elapsed + TIMEOUT_W'(1) : r_elapsed;
    assign n_elapsed = (up_start | dn_start) ? '0 : el_tick;
    assign n_count   = (up_start | dn_start) ? '0 : dec_count;
    assign in_time   = n_elapsed < i_cfg.timeout_ms;

    assign cnt_x   = {{(CMP_W-COUNT_BITS){n_count[COUNT_BITS-1]}}, n_count};
    assign thr_x   = {{(CMP_W-TRAVEL_W){1'b0}}, i_cfg.travel};
    assign up_done = cnt_x < -thr_x;
    assign dn_done = cnt_x >= thr_x;

    always_comb begin
        n_up_pend = up_req;
        n_dn_pend = dn_req;
        n_up_idle = r_up_idle;
        n_dn_idle = r_dn_idle;
        n_gear    = r_gear;
        pulse     = PULSE_STOP;
        led       = 1'b0;
        status    = STAT_NONE;
        if (conflict) begin
            n_up_pend = 1'b0;
            n_dn_pend = 1'b0;
            status    = STAT_CONFLICT;
        end else if (up_go) begin
            if (up_start) begin
                n_up_idle = 1'b0;
            end
            if (!up_ref && in_time) begin
                if (up_done) begin
                    n_up_pend = 1'b0;
                    n_up_idle = 1'b1;
                    n_gear    = r_gear + GEAR_W'(1);
                    status    = STAT_UP_DONE;
                end else begin
                    led   = 1'b1;
                    pulse = PULSE_UP;
                end
            end else begin
                n_up_pend = 1'b0;
                n_up_idle = 1'b1;
                status    = STAT_UP_ABORT;
            end
        end else if (dn_go) begin
            if (dn_start) begin
                n_dn_idle = 1'b0;
            end
            if (!dn_ref && in_time) begin
                if (dn_done) begin
                    n_dn_pend = 1'b0;
                    n_dn_idle = 1'b1;
                    n_gear    = r_gear - GEAR_W'(1);
                    status    = STAT_DOWN_DONE;
                end else begin
                    led   = 1'b1;
                    pulse = PULSE_DOWN;
                end
            end else begin
                n_dn_pend = 1'b0;
                n_dn_idle = 1'b1;
                status    = STAT_DOWN_ABORT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_last_a  <= 1'b0;
            r_last_b  <= 1'b0;
            r_up_pend <= 1'b0;
            r_dn_pend <= 1'b0;
            r_up_idle <= 1'b1;
            r_dn_idle <= 1'b1;
            r_elapsed <= '0;
            r_gear    <= GEAR_FIRST;
        end else if (i_step) begin
            r_count   <= n_count;
            r_last_a  <= i_word.enc_a;
            r_last_b  <= i_word.enc_b;
            r_up_pend <= n_up_pend;
            r_dn_pend <= n_dn_pend;
            r_up_idle <= n_up_idle;
            r_dn_idle <= n_dn_idle;
            r_elapsed <= n_elapsed;
            r_gear    <= n_gear;
        end
    end

    assign o_word.gear_now       = n_gear;
    assign o_word.ecu_duty       = duty_lut(n_gear);
    assign o_word.motor_pulse_us = pulse;
    assign o_word.shift_led      = led;
    assign o_word.shift_status   = status;
    assign o_word.travel_count   = cnt_x[15:0];

endmodule
